/* rtl/fixed_point_alu_top_defines.svh */
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Concurrent assertion forms used by the ALU execution pipeline.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_ALU_TOP_DEFINES_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, item types and helpers shared by the ALU modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int unsigned FPA_WIDTH     = 32;
    localparam int unsigned FPA_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_ABS = 3'd5,
        OP_CMP = 3'd6
    } op_t;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // operands already wrapped to the working width, held sign-extended in 32 bits
    typedef struct packed {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
    } fpa_item_t;

    typedef struct packed {
        logic      valid;
        fpa_item_t item;
    } fpa_slot_t;

    // keep bits up to sb, replicate bit sb above it
    function automatic logic [31:0] fpa_wrap32(input logic [31:0] v, input int unsigned sb);
        logic [31:0] o;
        for (int i = 0; i < 32; i++)
        begin
            o[i] = (i <= sb) ? v[i] : v[sb];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts input beats, decodes the opcode and wraps operands to WIDTH bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_front #(
    parameter int unsigned WIDTH = fpa_pkg::FPA_WIDTH
) (
    input  logic              s_tvalid,
    input  logic [63:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    output fpa_pkg::fpa_slot_t push
);
    import fpa_pkg::*;

    localparam int unsigned SB = (WIDTH < 32) ? WIDTH - 1 : 31;

    always_comb
    begin
        push.valid   = s_tvalid;
        push.item.op = op_t'(s_tuser);
        push.item.a  = fpa_wrap32(s_tdata[31:0], SB);
        push.item.b  = fpa_wrap32(s_tdata[63:32], SB);
    end

endmodule

`default_nettype wire

/* rtl/fpa_queue.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU decoupling queue
// Two-entry register FIFO between front end and execution pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fpa_pkg::fpa_slot_t push,
    output logic               push_ready,
    input  logic               pop,
    output fpa_pkg::fpa_slot_t head
);
    import fpa_pkg::*;

    fpa_item_t  ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

`default_nettype wire

/* rtl/fpa_back.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU execution pipeline
// Operand setup, split multiplier, one-bit-per-stage divider, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_point_alu_top_defines.svh"

module fpa_back #(
    parameter int unsigned WIDTH     = fpa_pkg::FPA_WIDTH,
    parameter int unsigned FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fpa_pkg::fpa_slot_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        result,
    output logic [1:0]         order,
    output logic               div_zero
);
    import fpa_pkg::*;

    localparam int unsigned SB   = (WIDTH < 32) ? WIDTH - 1 : 31;
    localparam int unsigned DSTG = WIDTH + FRAC_BITS;

    typedef struct packed {
        op_t              op;
        logic [31:0]      res;
        logic [1:0]       ord;
        logic             dz;
        logic             neg;
        logic [WIDTH-1:0] d;
        logic [WIDTH-1:0] n;
        logic [WIDTH-1:0] r;
        logic [31:0]      q;
    } stage_t;

    stage_t      pl_reg  [DSTG+1];
    logic        vld_reg [DSTG+1];
    stage_t      st0_next;
    logic        en;

    logic [63:0] pll_reg;
    logic [31:0] phl_reg, plh_reg;
    logic [63:0] mp_reg;
    logic [31:0] mul_res;

    logic        out_valid_reg;
    logic [31:0] res_reg, res_next;
    logic [1:0]  ord_reg;
    logic        dz_reg;

    logic signed [63:0] a64, b64, ma64, mb64, msh;

    // the whole pipeline advances together; stalls only when the output beat is held
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && head.valid;

    always_comb
    begin
        a64  = {{32{head.item.a[31]}}, head.item.a};
        b64  = {{32{head.item.b[31]}}, head.item.b};
        ma64 = a64[63] ? -a64 : a64;
        mb64 = b64[63] ? -b64 : b64;

        st0_next     = '0;
        st0_next.op  = head.item.op;
        st0_next.neg = a64[63] ^ b64[63];
        st0_next.n   = ma64[WIDTH-1:0];
        st0_next.d   = mb64[WIDTH-1:0];
        unique case (head.item.op)
            OP_ADD:  st0_next.res = fpa_wrap32(32'(a64 + b64), SB);
            OP_SUB:  st0_next.res = fpa_wrap32(32'(a64 - b64), SB);
            OP_NEG:  st0_next.res = fpa_wrap32(32'(-a64), SB);
            OP_ABS:  st0_next.res = fpa_wrap32(ma64[31:0], SB);
            OP_DIV:  st0_next.dz  = (b64 == 64'sd0);
            OP_CMP:
            begin
                if (a64 < b64)
                    st0_next.ord = ORD_LESS;
                else if (a64 == b64)
                    st0_next.ord = ORD_EQUAL;
                else
                    st0_next.ord = ORD_GREATER;
            end
            default: st0_next.res = '0;
        endcase
    end

    // low 64 bits of the product from three 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= 64'(a64[31:0] * b64[31:0]);
            phl_reg <= 32'(a64[63:32] * b64[31:0]);
            plh_reg <= 32'(a64[31:0] * b64[63:32]);
            mp_reg  <= pll_reg + {phl_reg + plh_reg, 32'd0};
            pl_reg[0] <= st0_next;
        end
    end

    always_comb
    begin
        msh     = $signed(mp_reg) >>> FRAC_BITS;
        mul_res = fpa_wrap32(msh[31:0], SB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= head.valid;
    end

    for (genvar k = 0; k < DSTG; k++)
    begin : g_div
        stage_t         nx;
        logic [WIDTH:0] t;

        // restoring step: bring in next dividend bit, subtract if it fits
        always_comb
        begin
            nx = pl_reg[k];
            t  = {pl_reg[k].r, pl_reg[k].n[WIDTH-1]};
            nx.n = {pl_reg[k].n[WIDTH-2:0], 1'b0};
            if (t >= {1'b0, pl_reg[k].d})
            begin
                nx.r = WIDTH'(t - {1'b0, pl_reg[k].d});
                nx.q = {pl_reg[k].q[30:0], 1'b1};
            end
            else
            begin
                nx.r = t[WIDTH-1:0];
                nx.q = {pl_reg[k].q[30:0], 1'b0};
            end
            if ((k == 1) && (pl_reg[k].op == OP_MUL))
                nx.res = mul_res;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pl_reg[k+1] <= nx;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end
    end

    always_comb
    begin
        res_next = pl_reg[DSTG].res;
        if ((pl_reg[DSTG].op == OP_DIV) && !pl_reg[DSTG].dz)
            res_next = fpa_wrap32(pl_reg[DSTG].neg ? (32'd0 - pl_reg[DSTG].q)
                                                   : pl_reg[DSTG].q, SB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[DSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            ord_reg <= pl_reg[DSTG].ord;
            dz_reg  <= pl_reg[DSTG].dz;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign order     = ord_reg;
    assign div_zero  = dz_reg;

    `FPA_ASSERT_NOW(a_dz_zero_res, out_valid_reg && dz_reg, res_reg == 32'd0,
        "divide-by-zero beat carries nonzero result")
    `FPA_ASSERT_NOW(a_dz_no_ord, out_valid_reg && dz_reg, ord_reg == ORD_LESS,
        "divide-by-zero beat carries compare outcome")
    `FPA_ASSERT_NOW(a_ord_range, out_valid_reg, ord_reg != 2'd3,
        "compare outcome out of range")
    `FPA_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_reg[0]) && $stable(out_valid_reg),
        "pipeline moved during output stall")

endmodule

`default_nettype wire

/* rtl/fixed_point_alu_top.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU top level
// Q-format add/sub/mul/div/negate/abs/compare over stream channels.
// ----------------------------------------------------------------------------
// The ALU accepts one beat per cycle while the output is not stalled and
// returns one result beat per input, in order. The pipeline depth is set by
// the divider, which resolves one quotient bit per pipeline stage; every
// operation travels the same pipeline so results stay in order.
// A two-entry queue sits between the input decode and the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_top #(
    parameter int unsigned WIDTH     = fpa_pkg::FPA_WIDTH,
    parameter int unsigned FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result[31:0], order[33:32], zero pad
    output logic [0:0]  m_tuser    // div_zero[0]
);
    import fpa_pkg::*;

    fpa_slot_t   push, head;
    logic        pop;
    logic [31:0] result;
    logic [1:0]  order;
    logic        div_zero;

    fpa_front #(.WIDTH(WIDTH)) u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (s_tready),
        .pop        (pop),
        .head       (head)
    );

    fpa_back #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result),
        .order     (order),
        .div_zero  (div_zero)
    );

    assign m_tdata = {6'd0, order, result};
    assign m_tuser = div_zero;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Streams directed and random operations through the ALU under varying
// backpressure and checks every result beat against a Q16.16 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int unsigned WIDTH     = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned LATENCY   = WIDTH + FRAC_BITS + 3;
    localparam int unsigned WATCHDOG  = 20000;
    localparam logic [2:0]  OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  order;
        logic        div_zero;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int       mismatches;

        function automatic logic [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [63:0] p;
            p = 64'(a) * 64'(b);
            p = p >>> FRAC_BITS;
            return p[31:0];
        endfunction

        function automatic logic [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [79:0] num;
            logic signed [79:0] q;
            num = 80'(a) <<< FRAC_BITS;
            q   = num / 80'(b);
            return q[31:0];
        endfunction

        function void note_operation(logic [2:0] op, logic signed [31:0] a,
                                     logic signed [31:0] b);
            alu_out_t e;
            e = '0;
            case (op)
                OP_ADD: e.result = a + b;
                OP_SUB: e.result = a - b;
                OP_MUL: e.result = fx_mul(a, b);
                OP_DIV:
                begin
                    if (b == 0) e.div_zero = 1'b1;
                    else        e.result   = fx_div(a, b);
                end
                OP_NEG: e.result = -a;
                OP_ABS: e.result = a[31] ? -a : a;
                OP_CMP: e.order = (a < b) ? ORD_LESS : (a == b) ? ORD_EQUAL : ORD_GREATER;
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(alu_out_t got);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h %0d %0d",
                             got.result, got.order, got.div_zero);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp res=%h ord=%0d dz=%0d got res=%h ord=%0d dz=%0d",
                             e.result, e.order, e.div_zero,
                             got.result, got.order, got.div_zero);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    alu_scoreboard sb;
    int  src_idle;
    int  snk_stall;
    int  quiet_cycles;
    bit  timed_out;

    fixed_point_alu_top #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side and result checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tdata[31:0], m_tdata[33:32], m_tuser[0]});
        if (rst_n)
            m_tready <= ($urandom_range(99) >= snk_stall);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // valid stays up after a beat until the next call decides to idle or send
    task automatic send_beat(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_operation(op, a, b);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(8) - 4;
            3: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
            4: return 32'($urandom_range(8) - 4) << FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int count);
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(49) == 0) ? OP_UNUSED : 3'($urandom_range(6));
            a  = rand_operand();
            b  = ($urandom_range(9) == 0) ? 32'd0 : rand_operand();
            if ($urandom_range(7) == 0) b = a;
            send_beat(op, a, b);
        end
    endtask

    task automatic run_directed();
        logic [31:0] edges[5];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000};
        for (int op = 0; op <= 7; op++)
            send_beat(3'(op), edges[op % 5], edges[(op + 1) % 5]);
        send_beat(OP_DIV, 32'h0003_0000, 32'h0);
        send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_beat(OP_DIV, 32'hfffd_0000, 32'h0002_0000);
        send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_beat(OP_NEG, 32'h8000_0000, 32'h0);
        send_beat(OP_ABS, 32'h8000_0000, 32'h0);
        send_beat(OP_ABS, 32'hffff_fffe, 32'hffff_ffff);
        send_beat(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
        send_beat(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_beat(OP_CMP, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_CMP, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(OP_CMP, 32'h0000_0001, 32'hffff_ffff);
    endtask

    initial
    begin
        sb        = new();
        src_idle  = 0;
        snk_stall = 0;
        timed_out = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(200);
        src_idle = 51;
        run_random(210);
        src_idle = 0;
        snk_stall = 51;
        run_random(210);
        src_idle = 26;
        snk_stall = 26;
        run_random(210);
        snk_stall = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 2) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("fixed_point_alu_top verification clean");
        else
            $display("fixed_point_alu_top verification failed");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_cycles >= WATCHDOG && !timed_out)
            begin
                timed_out = 1'b1;
                $display("fixed_point_alu_top verification failed");
                $finish;
            end
        end
    end
endmodule
